// ===== hw/rtl/bli_pkg.sv =====
// Shared constants and types of the brightness/luminance interpolator.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bli_pkg;

  // Default table depths
  localparam int DEF_POINT_DEPTH = 256;
  localparam int DEF_STEP_DEPTH  = 512;

  // Fixed field widths
  localparam int OPC_W     = 2;
  localparam int IDX_W     = 9;
  localparam int VAL_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int LUMX_W    = 23;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  localparam int LUM_SCALE    = 100;
  localparam int LUM_X100_MAX = 6553500;

  // Item opcodes
  localparam logic [OPC_W-1:0] OPC_WR_BRT  = 2'd0;
  localparam logic [OPC_W-1:0] OPC_WR_LUM  = 2'd1;
  localparam logic [OPC_W-1:0] OPC_WR_STEP = 2'd2;
  localparam logic [OPC_W-1:0] OPC_QUERY   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INDEX = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRT_USED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_USED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UI_USED   = 2'd2;

  // Which search a setup or capture refers to
  localparam logic [1:0] SRCH_UP   = 2'd0;
  localparam logic [1:0] SRCH_ST   = 2'd1;
  localparam logic [1:0] SRCH_STLO = 2'd2;
  localparam logic [1:0] SRCH_STHI = 2'd3;

  // Datapath micro-operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP    = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
  localparam logic [OP_W-1:0] OP_WRITE  = 5'd2;
  localparam logic [OP_W-1:0] OP_RNG_RD = 5'd3;
  localparam logic [OP_W-1:0] OP_RNG_CK = 5'd4;
  localparam logic [OP_W-1:0] OP_SETUP  = 5'd5;
  localparam logic [OP_W-1:0] OP_RD_BP  = 5'd6;
  localparam logic [OP_W-1:0] OP_S_RD0  = 5'd7;
  localparam logic [OP_W-1:0] OP_S_CK0  = 5'd8;
  localparam logic [OP_W-1:0] OP_S_RDN  = 5'd9;
  localparam logic [OP_W-1:0] OP_S_CKN  = 5'd10;
  localparam logic [OP_W-1:0] OP_S_PRB  = 5'd11;
  localparam logic [OP_W-1:0] OP_S_CKP  = 5'd12;
  localparam logic [OP_W-1:0] OP_S_CAP  = 5'd13;
  localparam logic [OP_W-1:0] OP_RD_LLO = 5'd14;
  localparam logic [OP_W-1:0] OP_RD_LHI = 5'd15;
  localparam logic [OP_W-1:0] OP_RD_LUI = 5'd16;
  localparam logic [OP_W-1:0] OP_HBM    = 5'd17;
  localparam logic [OP_W-1:0] OP_MUL    = 5'd18;
  localparam logic [OP_W-1:0] OP_SCALE  = 5'd19;
  localparam logic [OP_W-1:0] OP_DIV    = 5'd20;
  localparam logic [OP_W-1:0] OP_EMIT   = 5'd21;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      sel;
  } bli_cmd_t;

  typedef struct packed {
    logic hit;       // search compare ends the search
    logic empty;     // search window closed
    logic oor;       // brightness above last point
    logic div_done;  // divider finished
    logic out_busy;  // output register cannot take a result
  } bli_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/brightness_luminance_interpolator_core.sv =====
// Brightness-to-luminance interpolator, top level.
// Depends on bli_pkg, bli_ctrl, bli_dp (which holds the bli_ram tables).
//
// Items are processed one at a time. A table write latches the item,
// writes the table and then emits its result. A query makes four binary
// searches through single read ports with registered reads, then a
// restoring divider that retires one quotient bit per cycle for
// 23 + log2(STEP_DEPTH) quotient bits; query time is set mainly by the
// search probes and the divider. A range reject goes from the range
// read and check straight to emit. The next item is taken while a
// result waits in the output register. Configuration writes are taken at
// any cycle and must only be issued while the block is idle. Table
// contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module brightness_luminance_interpolator_core #(
  parameter int POINT_DEPTH = bli_pkg::DEF_POINT_DEPTH,
  parameter int STEP_DEPTH  = bli_pkg::DEF_STEP_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [bli_pkg::OPC_W-1:0]     in_opcode,
  input  wire logic [bli_pkg::IDX_W-1:0]     in_entry_index,
  input  wire logic [bli_pkg::VAL_W-1:0]     in_entry_value,
  input  wire logic [bli_pkg::VAL_W-1:0]     in_brightness,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bli_pkg::STATUS_W-1:0]       out_status,
  output logic [7:0]                         out_point_index,
  output logic [bli_pkg::VAL_W-1:0]          out_luminance,
  output logic [8:0]                         out_step_index,
  output logic [bli_pkg::LUMX_W-1:0]         out_luminance_x100,
  output logic                               out_high_brightness,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bli_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bli_pkg::CFG_DAT_W-1:0] cfg_data
);
  import bli_pkg::*;

  bli_cmd_t cmd;
  bli_sts_t sts;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  bli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  bli_dp #(
    .POINT_DEPTH (POINT_DEPTH),
    .STEP_DEPTH  (STEP_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_opcode           (in_opcode),
    .in_entry_index      (in_entry_index),
    .in_entry_value      (in_entry_value),
    .in_brightness       (in_brightness),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_point_index     (out_point_index),
    .out_luminance       (out_luminance),
    .out_step_index      (out_step_index),
    .out_luminance_x100  (out_luminance_x100),
    .out_high_brightness (out_high_brightness)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bli_ctrl.sv =====
// Controller state machine of the interpolator: sequences the datapath.
// Depends on bli_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bli_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [bli_pkg::OPC_W-1:0] in_opcode,
  input  wire bli_pkg::bli_sts_t         sts,
  output bli_pkg::bli_cmd_t              cmd
);
  import bli_pkg::*;

  localparam logic [4:0] C_IDLE   = 5'd0;
  localparam logic [4:0] C_WR     = 5'd1;
  localparam logic [4:0] C_RNG_RD = 5'd2;
  localparam logic [4:0] C_RNG_CK = 5'd3;
  localparam logic [4:0] C_SETUP  = 5'd4;
  localparam logic [4:0] C_RD0    = 5'd5;
  localparam logic [4:0] C_CK0    = 5'd6;
  localparam logic [4:0] C_RDN    = 5'd7;
  localparam logic [4:0] C_CKN    = 5'd8;
  localparam logic [4:0] C_PRB    = 5'd9;
  localparam logic [4:0] C_CKP    = 5'd10;
  localparam logic [4:0] C_CAP    = 5'd11;
  localparam logic [4:0] C_RDBP   = 5'd12;
  localparam logic [4:0] C_RD_LLO = 5'd13;
  localparam logic [4:0] C_RD_LHI = 5'd14;
  localparam logic [4:0] C_RD_LUI = 5'd15;
  localparam logic [4:0] C_HBM    = 5'd16;
  localparam logic [4:0] C_MUL    = 5'd17;
  localparam logic [4:0] C_SCALE  = 5'd18;
  localparam logic [4:0] C_DIV    = 5'd19;
  localparam logic [4:0] C_EMIT   = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic [1:0] srch_r, srch_nxt;

  assign in_ready = (state_r == C_IDLE);

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    srch_nxt  = srch_r;
    cmd.op    = OP_NOP;
    cmd.sel   = srch_r;
    case (state_r)
      C_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = (in_opcode == OPC_QUERY) ? C_RNG_RD : C_WR;
        end
      end
      C_WR: begin
        cmd.op    = OP_WRITE;
        state_nxt = C_EMIT;
      end
      C_RNG_RD: begin
        cmd.op    = OP_RNG_RD;
        state_nxt = C_RNG_CK;
      end
      C_RNG_CK: begin
        cmd.op    = OP_RNG_CK;
        srch_nxt  = SRCH_UP;
        state_nxt = sts.oor ? C_EMIT : C_SETUP;
      end
      C_SETUP: begin
        cmd.op    = OP_SETUP;
        state_nxt = C_RD0;
      end
      C_RD0: begin
        cmd.op    = OP_S_RD0;
        state_nxt = C_CK0;
      end
      C_CK0: begin
        cmd.op    = OP_S_CK0;
        state_nxt = sts.hit ? C_CAP : C_RDN;
      end
      C_RDN: begin
        cmd.op    = OP_S_RDN;
        state_nxt = C_CKN;
      end
      C_CKN: begin
        cmd.op    = OP_S_CKN;
        state_nxt = sts.hit ? C_CAP : C_PRB;
      end
      C_PRB: begin
        cmd.op    = OP_S_PRB;
        state_nxt = sts.empty ? C_CAP : C_CKP;
      end
      C_CKP: begin
        cmd.op    = OP_S_CKP;
        state_nxt = sts.hit ? C_CAP : C_PRB;
      end
      C_CAP: begin
        cmd.op = OP_S_CAP;
        case (srch_r)
          SRCH_UP: begin
            srch_nxt  = SRCH_ST;
            state_nxt = C_SETUP;
          end
          SRCH_ST: begin
            srch_nxt  = SRCH_STLO;
            state_nxt = C_RDBP;
          end
          SRCH_STLO: begin
            srch_nxt  = SRCH_STHI;
            state_nxt = C_RDBP;
          end
          default: state_nxt = C_RD_LLO;
        endcase
      end
      C_RDBP: begin
        cmd.op    = OP_RD_BP;
        state_nxt = C_SETUP;
      end
      C_RD_LLO: begin
        cmd.op    = OP_RD_LLO;
        state_nxt = C_RD_LHI;
      end
      C_RD_LHI: begin
        cmd.op    = OP_RD_LHI;
        state_nxt = C_RD_LUI;
      end
      C_RD_LUI: begin
        cmd.op    = OP_RD_LUI;
        state_nxt = C_HBM;
      end
      C_HBM: begin
        cmd.op    = OP_HBM;
        state_nxt = C_MUL;
      end
      C_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = C_SCALE;
      end
      C_SCALE: begin
        cmd.op    = OP_SCALE;
        state_nxt = C_DIV;
      end
      C_DIV: begin
        if (sts.div_done) begin
          state_nxt = C_EMIT;
        end else begin
          cmd.op = OP_DIV;
        end
      end
      C_EMIT: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_EMIT;
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      srch_r  <= SRCH_UP;
    end else begin
      state_r <= state_nxt;
      srch_r  <= srch_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bli_dp.sv =====
// Datapath of the interpolator: tables, search unit, multiply, divider,
// configuration registers and output register. Depends on bli_pkg, bli_ram.
`timescale 1ns / 1ps
`default_nettype none

module bli_dp #(
  parameter int POINT_DEPTH = bli_pkg::DEF_POINT_DEPTH,
  parameter int STEP_DEPTH  = bli_pkg::DEF_STEP_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bli_pkg::bli_cmd_t             cmd,
  output bli_pkg::bli_sts_t                  sts,
  input  wire logic [bli_pkg::OPC_W-1:0]     in_opcode,
  input  wire logic [bli_pkg::IDX_W-1:0]     in_entry_index,
  input  wire logic [bli_pkg::VAL_W-1:0]     in_entry_value,
  input  wire logic [bli_pkg::VAL_W-1:0]     in_brightness,
  input  wire logic                          cfg_valid,
  input  wire logic [bli_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bli_pkg::CFG_DAT_W-1:0] cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bli_pkg::STATUS_W-1:0]       out_status,
  output logic [7:0]                         out_point_index,
  output logic [bli_pkg::VAL_W-1:0]          out_luminance,
  output logic [8:0]                         out_step_index,
  output logic [bli_pkg::LUMX_W-1:0]         out_luminance_x100,
  output logic                               out_high_brightness
);
  import bli_pkg::*;

  localparam int PAW = $clog2(POINT_DEPTH);
  localparam int SAW = $clog2(STEP_DEPTH);
  localparam int MAW = (PAW > SAW) ? PAW : SAW;
  localparam int NW  = 23 + SAW;          // scaled numerator width
  localparam int CNW = $clog2(NW + 1);

  // Configuration registers
  logic [8:0] bpu_r;
  logic [9:0] spu_r;
  logic [8:0] uiu_r;

  // Latched item
  logic [OPC_W-1:0] opc_r;
  logic [IDX_W-1:0] idx_r;
  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] brt_r;
  logic             qry_r;
  logic [STATUS_W-1:0] status_r;

  // Search unit
  logic                  tsel_r;   // 0 brightness table, 1 step table
  logic [MAW:0]          n_r;
  logic [VAL_W-1:0]      sval_r;
  logic signed [MAW+1:0] lo_s_r, hi_s_r;
  logic [MAW-1:0]        res_r;

  // Query results
  logic [PAW-1:0]   up_r, lo_r;
  logic [SAW-1:0]   st_r, st_lo_r, st_hi_r;
  logic [VAL_W-1:0] lum_lo_r, lum_hi_r;
  logic             hbm_r;

  // Interpolation
  logic signed [SAW+17:0] prod_r;
  logic [NW-1:0]          num_r;
  logic [SAW-1:0]         den_r, rem_r;
  logic                   neg_r, zden_r;
  logic [CNW-1:0]         cnt_r;

  logic out_valid_r;

  // RAM ports
  logic [PAW-1:0]   bp_raddr, lp_raddr, p_waddr;
  logic [SAW-1:0]   sp_raddr, s_waddr;
  logic [VAL_W-1:0] bp_rdata, lp_rdata, sp_rdata, s_rdata;
  logic             bp_we, lp_we, sp_we, wr_bad;

  // Derived control values
  logic [31:0]           np32, ns32, idx32, uim1_32, res32;
  logic [MAW:0]          np, ns, nm1, npm1;
  logic                  ui_ok;
  logic signed [MAW+1:0] mid_s;
  logic [MAW-1:0]        mid;
  logic [MAW-1:0]        lo_clamp;

  // Interpolation helpers
  logic signed [16:0]    dlum;
  logic signed [SAW:0]   dst, dsth;
  logic [NW-1:0]         mag, num_w;
  logic [SAW:0]          trial;
  logic                  ge;
  logic [LUMX_W-1:0]     lumx;
  logic signed [NW+1:0]  base_s, q_s, acc_s;
  logic [LUMX_W-1:0]     acc_sat;
  logic [31:0]           up32, st32;

  // Saturate used counts to one through the depth
  always_comb begin
    if (bpu_r == 9'd0) begin
      np32 = 32'd1;
    end else if (32'(bpu_r) > 32'(POINT_DEPTH)) begin
      np32 = 32'(POINT_DEPTH);
    end else begin
      np32 = 32'(bpu_r);
    end
    if (spu_r == 10'd0) begin
      ns32 = 32'd1;
    end else if (32'(spu_r) > 32'(STEP_DEPTH)) begin
      ns32 = 32'(STEP_DEPTH);
    end else begin
      ns32 = 32'(spu_r);
    end
  end

  assign np      = np32[MAW:0];
  assign ns      = ns32[MAW:0];
  assign npm1    = np - 1'b1;
  assign nm1     = n_r - 1'b1;
  assign ui_ok   = (uiu_r != 9'd0) && (32'(uiu_r) <= np32);
  assign uim1_32 = 32'(uiu_r) - 32'd1;
  assign idx32   = 32'(idx_r);
  assign mid_s   = lo_s_r + ((hi_s_r - lo_s_r) >>> 1);
  assign mid     = mid_s[MAW-1:0];
  assign lo_clamp = (lo_s_r > $signed({1'b0, nm1})) ? nm1[MAW-1:0] : lo_s_r[MAW-1:0];
  assign res32   = 32'(res_r);

  // Table writes
  assign wr_bad  = (opc_r == OPC_WR_STEP) ? (idx32 >= 32'(STEP_DEPTH))
                                          : (idx32 >= 32'(POINT_DEPTH));
  assign p_waddr = idx32[PAW-1:0];
  assign s_waddr = idx32[SAW-1:0];
  assign bp_we   = (cmd.op == OP_WRITE) && !wr_bad && (opc_r == OPC_WR_BRT);
  assign lp_we   = (cmd.op == OP_WRITE) && !wr_bad && (opc_r == OPC_WR_LUM);
  assign sp_we   = (cmd.op == OP_WRITE) && !wr_bad && (opc_r == OPC_WR_STEP);

  // Read address selection
  always_comb begin
    bp_raddr = '0;
    sp_raddr = '0;
    lp_raddr = '0;
    case (cmd.op)
      OP_RNG_RD: bp_raddr = npm1[PAW-1:0];
      OP_RD_BP:  bp_raddr = (cmd.sel == SRCH_STLO) ? lo_r : up_r;
      OP_S_RDN: begin
        bp_raddr = nm1[PAW-1:0];
        sp_raddr = nm1[SAW-1:0];
      end
      OP_S_PRB: begin
        bp_raddr = mid[PAW-1:0];
        sp_raddr = mid[SAW-1:0];
      end
      OP_RD_LLO: lp_raddr = lo_r;
      OP_RD_LHI: lp_raddr = up_r;
      OP_RD_LUI: lp_raddr = uim1_32[PAW-1:0];
      default: begin
        bp_raddr = '0;
        sp_raddr = '0;
        lp_raddr = '0;
      end
    endcase
  end

  bli_ram #(.WIDTH(VAL_W), .DEPTH(POINT_DEPTH)) u_bp_ram (
    .clk(clk), .we(bp_we), .waddr(p_waddr), .wdata(val_r),
    .raddr(bp_raddr), .rdata(bp_rdata)
  );

  bli_ram #(.WIDTH(VAL_W), .DEPTH(POINT_DEPTH)) u_lp_ram (
    .clk(clk), .we(lp_we), .waddr(p_waddr), .wdata(val_r),
    .raddr(lp_raddr), .rdata(lp_rdata)
  );

  bli_ram #(.WIDTH(VAL_W), .DEPTH(STEP_DEPTH)) u_sp_ram (
    .clk(clk), .we(sp_we), .waddr(s_waddr), .wdata(val_r),
    .raddr(sp_raddr), .rdata(sp_rdata)
  );

  assign s_rdata = tsel_r ? sp_rdata : bp_rdata;

  // Status to the controller
  always_comb begin
    sts.hit      = ((cmd.op == OP_S_CK0) && (sval_r <= s_rdata)) ||
                   ((cmd.op == OP_S_CKN) && (sval_r >= s_rdata)) ||
                   ((cmd.op == OP_S_CKP) && (sval_r == s_rdata));
    sts.empty    = (lo_s_r > hi_s_r);
    sts.oor      = (brt_r > bp_rdata);
    sts.div_done = (cnt_r == '0);
    sts.out_busy = out_valid_r && !out_ready;
  end

  // Interpolation arithmetic
  assign dlum  = $signed({1'b0, lum_hi_r}) - $signed({1'b0, lum_lo_r});
  assign dst   = $signed({1'b0, st_r}) - $signed({1'b0, st_lo_r});
  assign dsth  = $signed({1'b0, st_hi_r}) - $signed({1'b0, st_lo_r});
  assign mag   = (prod_r < 0) ? NW'(-prod_r) : NW'(prod_r);
  assign num_w = (mag << 6) + (mag << 5) + (mag << 2);
  assign trial = {rem_r, num_r[NW-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign lumx  = LUMX_W'(lum_lo_r) * LUMX_W'(LUM_SCALE);
  assign base_s = $signed((NW+2)'(lumx));
  assign q_s    = zden_r ? '0 : $signed((NW+2)'(num_r));
  assign acc_s  = neg_r ? (base_s - q_s) : (base_s + q_s);

  always_comb begin
    if (acc_s < 0) begin
      acc_sat = '0;
    end else if (acc_s > $signed((NW+2)'(LUM_X100_MAX))) begin
      acc_sat = LUMX_W'(LUM_X100_MAX);
    end else begin
      acc_sat = acc_s[LUMX_W-1:0];
    end
  end

  assign up32 = 32'(up_r);
  assign st32 = 32'(st_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpu_r <= 9'd1;
      spu_r <= 10'd1;
      uiu_r <= 9'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BRT_USED:  bpu_r <= cfg_data[8:0];
        CFG_STEP_USED: spu_r <= cfg_data;
        CFG_UI_USED:   uiu_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Output valid: set on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Divider count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.op == OP_SCALE) begin
      cnt_r <= CNW'(NW);
    end else if (cmd.op == OP_DIV) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Payload registers, advanced by the micro-operation
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        opc_r <= in_opcode;
        idx_r <= in_entry_index;
        val_r <= in_entry_value;
        brt_r <= in_brightness;
        qry_r <= (in_opcode == OPC_QUERY);
      end
      OP_WRITE:  status_r <= wr_bad ? ST_INDEX : ST_OK;
      OP_RNG_CK: status_r <= sts.oor ? ST_RANGE : ST_OK;
      OP_SETUP: begin
        tsel_r <= (cmd.sel != SRCH_UP);
        n_r    <= (cmd.sel == SRCH_UP) ? np : ns;
        if (cmd.sel == SRCH_UP || cmd.sel == SRCH_ST) begin
          sval_r <= brt_r;
        end else begin
          sval_r <= bp_rdata;
        end
      end
      OP_S_CK0: res_r <= '0;
      OP_S_CKN: begin
        res_r  <= nm1[MAW-1:0];
        lo_s_r <= '0;
        hi_s_r <= $signed({1'b0, nm1});
      end
      OP_S_PRB: res_r <= lo_clamp;
      OP_S_CKP: begin
        res_r <= mid;
        if (s_rdata < sval_r) begin
          lo_s_r <= mid_s + 1'b1;
        end else begin
          hi_s_r <= mid_s - 1'b1;
        end
      end
      OP_S_CAP: begin
        case (cmd.sel)
          SRCH_UP: begin
            up_r <= res32[PAW-1:0];
            lo_r <= (res_r == '0) ? '0 : PAW'(res32 - 32'd1);
          end
          SRCH_ST:   st_r    <= res32[SAW-1:0];
          SRCH_STLO: st_lo_r <= res32[SAW-1:0];
          default:   st_hi_r <= res32[SAW-1:0];
        endcase
      end
      OP_RD_LHI: lum_lo_r <= lp_rdata;
      OP_RD_LUI: lum_hi_r <= lp_rdata;
      OP_HBM:    hbm_r    <= ui_ok && (lum_hi_r > lp_rdata);
      OP_MUL:    prod_r   <= dlum * dst;
      OP_SCALE: begin
        num_r  <= num_w;
        den_r  <= (dsth < 0) ? SAW'(-dsth) : SAW'(dsth);
        neg_r  <= (prod_r < 0) ^ (dsth < 0);
        zden_r <= (dsth == 0);
        rem_r  <= '0;
      end
      OP_DIV: begin
        rem_r <= ge ? SAW'(trial - {1'b0, den_r}) : trial[SAW-1:0];
        num_r <= {num_r[NW-2:0], ge};
      end
      OP_EMIT: begin
        out_status <= status_r;
        if (qry_r && status_r == ST_OK) begin
          out_point_index     <= up32[7:0];
          out_luminance       <= lum_hi_r;
          out_step_index      <= st32[8:0];
          out_luminance_x100  <= acc_sat;
          out_high_brightness <= hbm_r;
        end else begin
          out_point_index     <= '0;
          out_luminance       <= '0;
          out_step_index      <= '0;
          out_luminance_x100  <= '0;
          out_high_brightness <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  // A result is never emitted over one that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_EMIT |-> !(out_valid_r && !out_ready))
    else $error("result emitted into a busy output register");

  // The divider never steps past its last bit
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_DIV |-> cnt_r != '0)
    else $error("divider stepped with zero count");

  // A probe lies inside the open search window
  a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_S_PRB && !sts.empty) |-> (mid_s >= lo_s_r && mid_s <= hi_s_r))
    else $error("probe outside search window");

  // A captured search result lies inside the table
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_S_CAP |-> {1'b0, res_r} < n_r)
    else $error("search result beyond used entries");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the brightness/luminance interpolator core.
// Depends on bli_pkg and brightness_luminance_interpolator_core; self-checking
// through a scoreboard class that predicts every result from its own tables.
`timescale 1ns / 1ps

typedef struct {
  logic [1:0]  status;
  logic [7:0]  point_index;
  logic [15:0] luminance;
  logic [8:0]  step_index;
  logic [22:0] lum_x100;
  logic        high_brt;
} lum_result_t;

class lum_scoreboard;
  logic [15:0]  brt_tbl[256];
  logic [15:0]  lum_tbl[256];
  logic [15:0]  step_tbl[512];
  int unsigned  brt_used;
  int unsigned  step_used;
  int unsigned  ui_used;
  lum_result_t  pending_q[$];
  int           errors;

  function new();
    foreach (brt_tbl[i]) brt_tbl[i] = '0;
    foreach (lum_tbl[i]) lum_tbl[i] = '0;
    foreach (step_tbl[i]) step_tbl[i] = '0;
    brt_used  = 1;
    step_used = 1;
    ui_used   = 1;
    errors    = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [9:0] data);
    if (idx == bli_pkg::CFG_BRT_USED) brt_used = data[8:0];
    else if (idx == bli_pkg::CFG_STEP_USED) step_used = data;
    else if (idx == bli_pkg::CFG_UI_USED) ui_used = data[8:0];
  endfunction

  function int rd(bit from_step, int i);
    return from_step ? int'(step_tbl[i]) : int'(brt_tbl[i]);
  endfunction

  // Upper-bound search: first entry not below value, clamped to the used range
  function int find_upper(bit from_step, int n, int value);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = n - 1;
    if (value <= rd(from_step, 0)) return 0;
    if (value >= rd(from_step, hi)) return hi;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (rd(from_step, mid) == value) return mid;
      if (rd(from_step, mid) < value) lo = mid + 1;
      else hi = mid - 1;
    end
    if (lo > n - 1) lo = n - 1;
    return lo;
  endfunction

  // Predict the result of one accepted transaction and queue it
  function void note_input(logic [1:0] op, logic [8:0] idx, logic [15:0] val,
                           logic [15:0] brt);
    lum_result_t r;
    int np;
    int ns;
    int up;
    int lo;
    int st;
    int st_lo;
    int st_hi;
    longint acc;
    longint l_lo;
    longint l_hi;
    r = '{default: '0};
    if (op != bli_pkg::OPC_QUERY) begin
      if (op != bli_pkg::OPC_WR_STEP && idx >= 256) r.status = bli_pkg::ST_INDEX;
      else if (op == bli_pkg::OPC_WR_BRT) brt_tbl[idx] = val;
      else if (op == bli_pkg::OPC_WR_LUM) lum_tbl[idx] = val;
      else step_tbl[idx] = val;
      pending_q.push_back(r);
      return;
    end
    np = (brt_used < 1) ? 1 : (brt_used > 256) ? 256 : brt_used;
    ns = (step_used < 1) ? 1 : (step_used > 512) ? 512 : step_used;
    if (brt > brt_tbl[np-1]) begin
      r.status = bli_pkg::ST_RANGE;
      pending_q.push_back(r);
      return;
    end
    up    = find_upper(0, np, brt);
    lo    = (up > 0) ? up - 1 : 0;
    st    = find_upper(1, ns, brt);
    st_lo = find_upper(1, ns, brt_tbl[lo]);
    st_hi = find_upper(1, ns, brt_tbl[up]);
    l_lo  = lum_tbl[lo];
    l_hi  = lum_tbl[up];
    acc   = l_lo * 100;
    if (st_hi != st_lo) acc += ((l_hi - l_lo) * longint'(st - st_lo) * 100) / longint'(st_hi - st_lo);
    if (acc < 0) acc = 0;
    if (acc > bli_pkg::LUM_X100_MAX) acc = bli_pkg::LUM_X100_MAX;
    r.status      = bli_pkg::ST_OK;
    r.point_index = up[7:0];
    r.luminance   = lum_tbl[up];
    r.step_index  = st[8:0];
    r.lum_x100    = acc[22:0];
    if (ui_used >= 1 && ui_used <= np) r.high_brt = lum_tbl[up] > lum_tbl[ui_used-1];
    pending_q.push_back(r);
  endfunction

  function void cmp_field(string name, longint e, longint a);
    if (e != a) begin
      errors++;
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
    end
  endfunction

  function void check_result(lum_result_t got);
    lum_result_t e;
    if (pending_q.size() == 0) begin
      errors++;
      $display("%0t unexpected result: expected none actual status %0d", $time, got.status);
      return;
    end
    e = pending_q.pop_front();
    cmp_field("status", e.status, got.status);
    cmp_field("point_index", e.point_index, got.point_index);
    cmp_field("luminance", e.luminance, got.luminance);
    cmp_field("step_index", e.step_index, got.step_index);
    cmp_field("luminance_x100", e.lum_x100, got.lum_x100);
    cmp_field("high_brightness", e.high_brt, got.high_brt);
  endfunction
endclass

module tb;
  import bli_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [8:0]  in_entry_index;
  logic [15:0] in_entry_value;
  logic [15:0] in_brightness;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_point_index;
  logic [15:0] out_luminance;
  logic [8:0]  out_step_index;
  logic [22:0] out_luminance_x100;
  logic        out_high_brightness;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;

  lum_scoreboard sb;
  int  idle_pct;
  int  stall_pct;
  bit  hold_req;
  bit  hold_done;
  int  quiet_cycles;
  // shadow of the tables as written, for shaping stimulus
  logic [15:0] brt_sh[256];
  logic [15:0] lum_sh[256];
  logic [15:0] step_sh[512];
  int  np_eff;
  int  ns_eff;

  brightness_luminance_interpolator_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_entry_index(in_entry_index),
    .in_entry_value(in_entry_value), .in_brightness(in_brightness),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_point_index(out_point_index),
    .out_luminance(out_luminance), .out_step_index(out_step_index),
    .out_luminance_x100(out_luminance_x100),
    .out_high_brightness(out_high_brightness),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    int hold_cnt;
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      out_ready <= 1'b0;
      for (hold_cnt = 0; hold_cnt < 2000; hold_cnt++) @(posedge clk);
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check each result transaction
  always @(posedge clk) begin
    lum_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status      = out_status;
      got.point_index = out_point_index;
      got.luminance   = out_luminance;
      got.step_index  = out_step_index;
      got.lum_x100    = out_luminance_x100;
      got.high_brt    = out_high_brightness;
      sb.check_result(got);
    end
  end

  // Watchdog: count cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic [1:0] op, logic [8:0] idx, logic [15:0] val,
                           logic [15:0] brt);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_brightness  <= brt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(op, idx, val, brt);
    if (op == OPC_WR_BRT && idx < 256) brt_sh[idx] = val;
    else if (op == OPC_WR_LUM && idx < 256) lum_sh[idx] = val;
    else if (op == OPC_WR_STEP) step_sh[idx] = val;
  endtask

  // Hold valid after the transaction; the caller drops it
  task automatic write_reg(logic [1:0] idx, logic [9:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Wait until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Configure the used counts and load ascending brightness and step tables and a luminance table over the used range
  task automatic setup_phase(int brt_n, int step_n, int ui_n);
    int fill;
    int i;
    int acc;
    write_reg(CFG_BRT_USED, 10'(brt_n));
    write_reg(CFG_STEP_USED, 10'(step_n));
    write_reg(CFG_UI_USED, 10'(ui_n));
    cfg_valid <= 1'b0;
    np_eff = (brt_n[8:0] < 1) ? 1 : (brt_n[8:0] > 256) ? 256 : brt_n[8:0];
    ns_eff = (step_n < 1) ? 1 : (step_n > 512) ? 512 : step_n;
    fill = np_eff;
    if (ui_n[8:0] > fill) fill = (ui_n[8:0] > 256) ? 256 : ui_n[8:0];
    acc = $urandom_range(300);
    for (i = 0; i < fill; i++) begin
      send_item(OPC_WR_BRT, 9'(i), 16'(acc), '0);
      send_item(OPC_WR_LUM, 9'(i), 16'($urandom_range(65535 * (i + 1) / fill)), '0);
      acc += $urandom_range(65535 / fill);
      if (acc > 65535) acc = 65535;
    end
    acc = $urandom_range(200);
    for (i = 0; i < ns_eff; i++) begin
      send_item(OPC_WR_STEP, 9'(i), 16'(acc), '0);
      acc += $urandom_range(65535 / ns_eff);
      if (acc > 65535) acc = 65535;
    end
  endtask

  // Mostly well-formed queries and order-keeping writes, some noise
  task automatic random_item();
    int r;
    int k;
    int lo_v;
    int hi_v;
    int b;
    r = $urandom_range(99);
    if (r < 55) begin
      if (r < 8) b = $urandom_range(65535);
      else if (r < 13) b = (brt_sh[np_eff-1] == 16'hFFFF) ? 16'hFFFF :
                           $urandom_range(65535, brt_sh[np_eff-1] + 1);
      else begin
        k = $urandom_range(np_eff - 1);
        b = int'(brt_sh[k]) + $urandom_range(2) - 1;
        if (k > 0 && $urandom_range(1)) b = $urandom_range(brt_sh[k], brt_sh[k-1]);
        if (b < 0) b = 0;
        if (b > 65535) b = 65535;
      end
      send_item(OPC_QUERY, 9'($urandom_range(511)), 16'($urandom_range(65535)), 16'(b));
    end else if (r < 75) begin
      k = $urandom_range(np_eff - 1);
      if ($urandom_range(1)) begin
        lo_v = (k > 0) ? brt_sh[k-1] : 0;
        hi_v = (k < np_eff - 1) ? brt_sh[k+1] : 65535;
        if (r < 72) send_item(OPC_WR_BRT, 9'(k), 16'($urandom_range(hi_v, lo_v)), '0);
        else send_item(OPC_WR_BRT, 9'(k), 16'($urandom_range(65535)), '0);
      end else begin
        send_item(OPC_WR_LUM, 9'(k), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)));
      end
    end else if (r < 85) begin
      k = $urandom_range(ns_eff - 1);
      lo_v = (k > 0) ? step_sh[k-1] : 0;
      hi_v = (k < ns_eff - 1) ? step_sh[k+1] : 65535;
      if (r < 83) send_item(OPC_WR_STEP, 9'(k), 16'($urandom_range(hi_v, lo_v)), '0);
      else send_item(OPC_WR_STEP, 9'(k), 16'($urandom_range(65535)), '0);
    end else if (r < 92) begin
      // write at a random index; it may lie past the used range or out of the table
      send_item(2'($urandom_range(2)), 9'($urandom_range(511)),
                16'($urandom_range(65535)), 16'($urandom_range(65535)));
    end else begin
      send_item(2'($urandom_range(1)), 9'($urandom_range(511, 256)),
                16'($urandom_range(65535)), '0);
    end
  endtask

  task automatic run_phase(int brt_n, int step_n, int ui_n, int idle, int stall, int n);
    int i;
    drain();
    idle_pct  = 0;
    stall_pct = 0;
    setup_phase(brt_n, step_n, ui_n);
    idle_pct  = idle;
    stall_pct = stall;
    for (i = 0; i < n; i++) random_item();
  endtask

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_opcode = '0;
    in_entry_index = '0;
    in_entry_value = '0;
    in_brightness  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of brightness, range reject, bad write indexes
    setup_phase(4, 4, 2);
    send_item(OPC_QUERY, '0, '0, 16'h0000);
    send_item(OPC_QUERY, '1, '1, brt_sh[0]);
    send_item(OPC_QUERY, '0, '0, brt_sh[3]);
    send_item(OPC_QUERY, '0, '0, 16'(brt_sh[3] + 1));
    send_item(OPC_QUERY, '0, '0, 16'hFFFF);
    send_item(OPC_WR_BRT, 9'd256, 16'hFFFF, '0);
    send_item(OPC_WR_LUM, 9'd511, 16'hFFFF, '0);
    send_item(OPC_WR_STEP, 9'd511, 16'hFFFF, '0);
    send_item(OPC_WR_STEP, 9'd511, 16'h0000, '0);
    send_item(OPC_WR_LUM, 9'd3, 16'hFFFF, '0);
    send_item(OPC_WR_BRT, 9'd3, 16'hFFFF, '0);
    send_item(OPC_QUERY, '0, '0, 16'hFFFF);
    // equal steps at both bounds: zero interpolation
    send_item(OPC_WR_STEP, 9'd0, 16'h0000, '0);
    send_item(OPC_WR_STEP, 9'd1, 16'h0000, '0);
    send_item(OPC_WR_STEP, 9'd2, 16'h0000, '0);
    send_item(OPC_WR_STEP, 9'd3, 16'h0000, '0);
    send_item(OPC_QUERY, '0, '0, 16'(brt_sh[2] + 1));
    idle_pct = 0; stall_pct = 0;
    for (int i = 0; i < 30; i++) random_item();

    // Used counts of zero saturate to one; normal-range count of zero
    run_phase(0, 0, 0, 73, 0, 40);
    run_phase(16, 40, 12, 73, 0, 80);
    // Largest settings: counts above depth saturate to the full tables
    run_phase(511, 1023, 256, 0, 0, 60);
    // Normal-range count beyond the used points
    run_phase(20, 30, 25, 0, 73, 80);
    run_phase(12, 12, 12, 10, 10, 60);
    // Long receiver hold-off while the sender keeps offering
    drain();
    setup_phase(8, 16, 5);
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1;
    for (int i = 0; i < 60; i++) random_item();

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/bli_pkg.sv
hw/rtl/bli_ram.sv
hw/rtl/bli_ctrl.sv
hw/rtl/bli_dp.sv
hw/rtl/brightness_luminance_interpolator_core.sv
verif/tb.sv
